### src/qrs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_pkg
// shared types and constants of the quadratic root solver
// ---------------------------------------------------------------------------
package qrs_pkg;

   localparam int COEF_W  = 16;
   localparam int VAL_W   = 32;
   localparam int OUT_FRAC = 16;
   // discriminant magnitude, square root, numerator, divisor and quotient widths
   localparam int DMAG_W  = 2 * COEF_W + 2;
   localparam int ROOT_W  = DMAG_W / 2;
   localparam int NUM_W   = COEF_W + 2;
   localparam int DEN_W   = COEF_W + 1;
   localparam int QUO_W   = NUM_W + OUT_FRAC;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_AZ  = 2'd1;
   localparam logic [1:0] STATUS_SAT = 2'd2;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
   } req_word_type;

   typedef struct packed {
      logic                    real_roots;
      logic signed [VAL_W-1:0] first_value;
      logic signed [VAL_W-1:0] second_value;
      logic [1:0]              status;
   } rsp_word_type;

   typedef struct packed {
      logic                     valid;
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic                     dpos;
   } sq_meta_type;

   typedef struct packed {
      logic valid;
      logic neg1;
      logic neg2;
      logic dpos;
      logic azero;
   } dv_meta_type;

endpackage
`default_nettype wire

### src/quadratic_root_solver.sv
`default_nettype none
// ---------------------------------------------------------------------------
// quadratic_root_solver
// roots of a*x^2 + b*x + c from Q8.8 coefficients, Q16.16 saturated results
// ---------------------------------------------------------------------------
// pipeline: 3 front stages, 17 square root stages, 1 numerator stage,
//   34 divider stages, 1 output stage
// throughput: one word per cycle; a stalled result freezes the whole pipeline
// reset: synchronous, clears all valid bits, no words in flight afterward
module quadratic_root_solver
   import qrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   logic enable;

   logic                     v0_ff, v1_ff, v2_ff, v3_ff;
   logic signed [COEF_W-1:0] a0_ff, b0_ff, c0_ff, a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [2*COEF_W-1:0] bb1_ff, ac1_ff;
   logic                     dpos2_ff;
   logic [DMAG_W-1:0]        dmag2_ff;

   sq_meta_type sq_meta_ff [ROOT_W];
   dv_meta_type dv_meta_ff [QUO_W];

   logic [ROOT_W-1:0] root;
   logic [QUO_W-1:0]  n1_ff, n2_ff, q1, q2;
   logic [DEN_W-1:0]  den_ff;
   logic              neg1_ff, neg2_ff, dpos3_ff, azero3_ff;

   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = rsp_valid_ff && rsp_stall;

   // front end: register, multiply, discriminant
   logic signed [DMAG_W:0] disc;
   assign disc = (DMAG_W+1)'(bb1_ff) - (DMAG_W+1)'($signed({ac1_ff, 2'b00}));

   always_ff @(posedge clock) begin
      if (enable) begin
         a0_ff    <= req_word.coef_a;
         b0_ff    <= req_word.coef_b;
         c0_ff    <= req_word.coef_c;
         a1_ff    <= a0_ff;
         b1_ff    <= b0_ff;
         bb1_ff   <= b0_ff * b0_ff;
         ac1_ff   <= a0_ff * c0_ff;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         dpos2_ff <= !disc[DMAG_W] && (disc != '0);
         dmag2_ff <= disc[DMAG_W] ? DMAG_W'(-disc) : DMAG_W'(disc);
      end
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   qrs_sqrt u_sqrt (
      .clock   (clock),
      .enable  (enable),
      .radicand(dmag2_ff),
      .root    (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_W; i++) begin
            sq_meta_ff[i] <= '0;
         end
      end else if (enable) begin
         sq_meta_ff[0] <= '{valid: v2_ff, a: a2_ff, b: b2_ff, dpos: dpos2_ff};
         for (int i = 1; i < ROOT_W; i++) begin
            sq_meta_ff[i] <= sq_meta_ff[i-1];
         end
      end
   end

   // numerators and divisor magnitudes
   sq_meta_type            sq_out;
   logic signed [NUM_W:0]  nb, s_ext, n1, n2;
   assign sq_out = sq_meta_ff[ROOT_W-1];
   assign nb     = -(NUM_W+1)'(sq_out.b);
   assign s_ext  = (NUM_W+1)'({1'b0, root});
   assign n1     = sq_out.dpos ? nb + s_ext : nb;
   assign n2     = sq_out.dpos ? nb - s_ext : s_ext;

   always_ff @(posedge clock) begin
      if (enable) begin
         n1_ff     <= {NUM_W'(n1[NUM_W] ? -n1 : n1), OUT_FRAC'(0)};
         n2_ff     <= {NUM_W'(n2[NUM_W] ? -n2 : n2), OUT_FRAC'(0)};
         den_ff    <= sq_out.a[COEF_W-1] ? DEN_W'(-{sq_out.a, 1'b0})
                                         : DEN_W'({sq_out.a, 1'b0});
         neg1_ff   <= n1[NUM_W] ^ sq_out.a[COEF_W-1];
         neg2_ff   <= n2[NUM_W] ^ sq_out.a[COEF_W-1];
         dpos3_ff  <= sq_out.dpos;
         azero3_ff <= (sq_out.a == '0);
      end
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff <= sq_out.valid;
      end
   end

   qrs_div u_div1 (
      .clock   (clock),
      .enable  (enable),
      .dividend(n1_ff),
      .divisor (den_ff),
      .quotient(q1)
   );

   qrs_div u_div2 (
      .clock   (clock),
      .enable  (enable),
      .dividend(n2_ff),
      .divisor (den_ff),
      .quotient(q2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUO_W; i++) begin
            dv_meta_ff[i] <= '0;
         end
      end else if (enable) begin
         dv_meta_ff[0] <= '{valid: v3_ff, neg1: neg1_ff, neg2: neg2_ff,
                            dpos: dpos3_ff, azero: azero3_ff};
         for (int i = 1; i < QUO_W; i++) begin
            dv_meta_ff[i] <= dv_meta_ff[i-1];
         end
      end
   end

   // sign and saturation
   dv_meta_type      dv_out;
   logic [VAL_W-1:0] v1, v2;
   logic             sat1, sat2;
   assign dv_out = dv_meta_ff[QUO_W-1];

   always_comb begin
      if (!dv_out.neg1) begin
         sat1 = (q1[QUO_W-1:VAL_W-1] != '0);
         v1   = sat1 ? {1'b0, {(VAL_W-1){1'b1}}} : q1[VAL_W-1:0];
      end else begin
         sat1 = (q1 > {1'b1, {(VAL_W-1){1'b0}}});
         v1   = sat1 ? {1'b1, {(VAL_W-1){1'b0}}} : -q1[VAL_W-1:0];
      end
      if (!dv_out.neg2) begin
         sat2 = (q2[QUO_W-1:VAL_W-1] != '0);
         v2   = sat2 ? {1'b0, {(VAL_W-1){1'b1}}} : q2[VAL_W-1:0];
      end else begin
         sat2 = (q2 > {1'b1, {(VAL_W-1){1'b0}}});
         v2   = sat2 ? {1'b1, {(VAL_W-1){1'b0}}} : -q2[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_word_ff.real_roots <= dv_out.dpos;
         if (dv_out.azero) begin
            rsp_word_ff.first_value  <= '0;
            rsp_word_ff.second_value <= '0;
            rsp_word_ff.status       <= STATUS_AZ;
         end else begin
            rsp_word_ff.first_value  <= v1;
            rsp_word_ff.second_value <= v2;
            rsp_word_ff.status       <= (sat1 || sat2) ? STATUS_SAT : STATUS_OK;
         end
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dv_out.valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

### src/qrs_sqrt.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_sqrt
// pipelined floor square root, one result bit per stage
// ---------------------------------------------------------------------------
module qrs_sqrt
   import qrs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [DMAG_W-1:0] radicand,
   output logic [ROOT_W-1:0]      root
);

   localparam int REM_W = ROOT_W + 2;

   logic [DMAG_W-1:0] num_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic [DMAG_W-1:0] num_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  test;

      if (i == 0) begin : g_first
         assign num_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign num_prev  = num_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
      end

      // bring down two radicand bits, try root*4+1
      assign trial = {rem_prev, num_prev[DMAG_W-1 -: 2]};
      assign test  = {2'b00, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[i] <= {num_prev[DMAG_W-3:0], 2'b00};
            if (trial >= test) begin
               rem_ff[i]  <= REM_W'(trial - test);
               root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[i]  <= trial[REM_W-1:0];
               root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

### src/qrs_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module qrs_div
   import qrs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [QUO_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic [QUO_W-1:0]      quotient
);

   logic [QUO_W-1:0] num_ff [QUO_W];
   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic [QUO_W-1:0] num_prev;
      logic [DEN_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [DEN_W:0]   trial;

      if (i == 0) begin : g_first
         assign num_prev = dividend;
         assign rem_prev = '0;
         assign den_prev = divisor;
      end else begin : g_next
         assign num_prev = num_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
      end

      assign trial = {rem_prev, num_prev[QUO_W-1]};

      // dividend bits shift out at the top, quotient bits shift in below
      always_ff @(posedge clock) begin
         if (enable) begin
            den_ff[i] <= den_prev;
            if (trial >= {1'b0, den_prev}) begin
               rem_ff[i] <= DEN_W'(trial - {1'b0, den_prev});
               num_ff[i] <= {num_prev[QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= trial[DEN_W-1:0];
               num_ff[i] <= {num_prev[QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   assign quotient = num_ff[QUO_W-1];

endmodule
`default_nettype wire

### src/qrs_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_checker
// port level checks of the quadratic root solver
// ---------------------------------------------------------------------------
module qrs_checker
   import qrs_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_word_type req_word,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_word
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // back pressure comes only from a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall without stalled result");

   // zero a gives zero values
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STATUS_AZ |->
         rsp_word.first_value == '0 && rsp_word.second_value == '0)
      else $error("zero a result has nonzero values");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
`default_nettype wire
